>>> rtl/drbt_pkg.sv
`default_nettype none
// ============================================================================
// drbt_pkg
// Shared types and constants of the dirty region bitmap tracker: field widths,
// operation and register codes, controller/datapath command and status.
// ============================================================================
package drbt_pkg;

    // fixed widths
    localparam int WORD_BITS = 32;
    localparam int WORD_LSB  = 5;
    localparam int COORD_W   = 13;
    localparam int DIM_W     = 11;
    localparam int COUNT_W   = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    // default screen limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_RECT   = 2'd0,
        FUNC_PIXEL  = 2'd1,
        FUNC_SWITCH = 2'd2,
        FUNC_QUERY  = 2'd3
    } func_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic q_zero;
        logic walk;
        logic flip;
        logic clr_start;
        logic clr_step;
        logic q_capture;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic  enable;
        func_t func;
        logic  rect_empty;
        logic  walk_last;
        logic  clr_last;
        logic  out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/drbt_ram.sv
`default_nettype none
// ============================================================================
// drbt_ram
// Generic single-write, single-read memory with registered read data.
// ============================================================================
module drbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/drbt_ctrl.sv
`default_nettype none
// ============================================================================
// drbt_ctrl
// Sequencer of the tracker: clearing passes, rectangle walk, query read and
// handoff of the result to the output register.
// ============================================================================
module drbt_ctrl
    import drbt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_INIT_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_MARK,
        ST_FLUSH,
        ST_QREAD,
        ST_SW_CLEAR,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.q_zero = !(stat.enable && (stat.func == FUNC_QUERY));
                if (!stat.enable)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    case (stat.func)
                        FUNC_RECT, FUNC_PIXEL:
                        begin
                            state_next = stat.rect_empty ? ST_DONE : ST_MARK;
                        end
                        FUNC_SWITCH:
                        begin
                            cmd.flip      = 1'b1;
                            cmd.clr_start = 1'b1;
                            state_next    = ST_SW_CLEAR;
                        end
                        FUNC_QUERY:
                        begin
                            state_next = ST_QREAD;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MARK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DONE;
            end
            ST_QREAD:
            begin
                cmd.q_capture = 1'b1;
                state_next    = ST_DONE;
            end
            ST_SW_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // input side takes a transfer only between operations
    assign in_stall = (state_reg != ST_IDLE);

endmodule
`default_nettype wire

>>> rtl/drbt_dpath.sv
`default_nettype none
// ============================================================================
// drbt_dpath
// Datapath of the tracker: configuration registers, coordinate clamping,
// walk counters, read-modify-write stage, the two frame bitmaps and row
// counters, and the result and output registers.
// ============================================================================
module drbt_dpath
    import drbt_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic        [CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [DIM_W-1:0]     cfg_data,
    input  wire logic        [1:0]           func,
    input  wire logic signed [COORD_W-1:0]   x_first,
    input  wire logic signed [COORD_W-1:0]   y_first,
    input  wire logic signed [COORD_W-1:0]   x_last,
    input  wire logic signed [COORD_W-1:0]   y_last,
    input  wire logic                        out_stall,
    output logic                             out_valid,
    output logic             [WORD_BITS-1:0] dirty_word,
    output logic             [COUNT_W-1:0]   row_count_now,
    output logic             [COUNT_W-1:0]   row_count_before,
    input  wire dp_cmd_t                     cmd,
    output dp_stat_t                         stat
);

    localparam int XW = ($clog2(MAX_WIDTH) > WORD_LSB) ? $clog2(MAX_WIDTH) : WORD_LSB + 1;
    localparam int WW = XW - WORD_LSB;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW = YW + WW;
    localparam int FRAME_WORDS = MAX_HEIGHT * (2 ** WW);
    localparam logic [COORD_W-1:0] MAXW_C   = COORD_W'(MAX_WIDTH);
    localparam logic [COORD_W-1:0] MAXH_C   = COORD_W'(MAX_HEIGHT);
    localparam logic [AW-1:0]      CLR_LAST = AW'(FRAME_WORDS - 1);
    localparam logic [AW-1:0]      CNT_ROWS = AW'(MAX_HEIGHT);

    // clamp a signed coordinate to 0 .. lim-1
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic [COORD_W-1:0] v,
        input logic [COORD_W-1:0] lim
    );
        logic [COORD_W-1:0] r;
        if (v[COORD_W-1])
            r = '0;
        else if (v >= lim)
            r = lim - 1'b1;
        else
            r = v;
        return r;
    endfunction

    // configuration
    logic             en_reg;
    logic [DIM_W-1:0] sw_reg;
    logic [DIM_W-1:0] sh_reg;

    logic [COORD_W-1:0] eff_w;
    logic [COORD_W-1:0] eff_h;
    logic [COORD_W-1:0] xa_c;
    logic [COORD_W-1:0] ya_c;
    logic [COORD_W-1:0] xb_c;
    logic [COORD_W-1:0] yb_c;

    // operation and walk
    func_t          func_reg;
    logic [XW-1:0]  x1_reg;
    logic [XW-1:0]  x2_reg;
    logic [YW-1:0]  y2_reg;
    logic [YW-1:0]  row_reg;
    logic [WW-1:0]  word_reg;
    logic [WW-1:0]  w1;
    logic [WW-1:0]  w2;
    logic [XW:0]    span;
    logic [WORD_LSB-1:0]  lo;
    logic [WORD_LSB-1:0]  hi;
    logic [WORD_BITS-1:0] mask;

    // frame and clearing pass
    logic          frame_reg;
    logic [AW-1:0] clr_reg;
    logic [1:0]    clr_sel_reg;
    logic          clr_cnt_row;

    // read-modify-write stage
    logic                 p_valid_reg;
    logic                 p_first_reg;
    logic [AW-1:0]        p_addr_reg;
    logic [YW-1:0]        p_row_reg;
    logic [WORD_BITS-1:0] p_mask_reg;

    // memories
    logic [1:0]           dw_we;
    logic [WORD_BITS-1:0] dw_wdata [2];
    logic [WORD_BITS-1:0] dw_rdata [2];
    logic [1:0]           cnt_we;
    logic [COUNT_W-1:0]   cnt_wdata [2];
    logic [COUNT_W-1:0]   cnt_rdata [2];
    logic [COUNT_W:0]     cnt_sum   [2];
    logic [AW-1:0]        dw_waddr;
    logic [YW-1:0]        cnt_waddr;

    // result and output
    logic [WORD_BITS-1:0] hold_dirty_reg;
    logic [COUNT_W-1:0]   hold_now_reg;
    logic [COUNT_W-1:0]   hold_before_reg;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] out_dirty_reg;
    logic [COUNT_W-1:0]   out_now_reg;
    logic [COUNT_W-1:0]   out_before_reg;

    // effective screen size
    always_comb
    begin
        if (sw_reg == '0)
            eff_w = COORD_W'(1);
        else if ({2'b00, sw_reg} > MAXW_C)
            eff_w = MAXW_C;
        else
            eff_w = {2'b00, sw_reg};
        if (sh_reg == '0)
            eff_h = COORD_W'(1);
        else if ({2'b00, sh_reg} > MAXH_C)
            eff_h = MAXH_C;
        else
            eff_h = {2'b00, sh_reg};
    end

    assign xa_c = clamp_coord(x_first, eff_w);
    assign ya_c = clamp_coord(y_first, eff_h);
    assign xb_c = clamp_coord(x_last, eff_w);
    assign yb_c = clamp_coord(y_last, eff_h);

    // word span and mask of the current word
    assign w1   = x1_reg[XW-1:WORD_LSB];
    assign w2   = x2_reg[XW-1:WORD_LSB];
    assign span = {1'b0, x2_reg} - {1'b0, x1_reg} + (XW+1)'(1);
    assign lo   = (word_reg == w1) ? x1_reg[WORD_LSB-1:0] : '0;
    assign hi   = (word_reg == w2) ? x2_reg[WORD_LSB-1:0] : '1;
    assign mask = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (~hi));

    // operation capture and walk counters
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func_t'(func);
            x1_reg   <= xa_c[XW-1:0];
            row_reg  <= ya_c[YW-1:0];
            word_reg <= xa_c[XW-1:WORD_LSB];
            if (func_t'(func) == FUNC_PIXEL)
            begin
                x2_reg <= xa_c[XW-1:0];
                y2_reg <= ya_c[YW-1:0];
            end
            else
            begin
                x2_reg <= xb_c[XW-1:0];
                y2_reg <= yb_c[YW-1:0];
            end
        end
        else if (cmd.walk)
        begin
            if (word_reg == w2)
            begin
                word_reg <= w1;
                row_reg  <= row_reg + 1'b1;
            end
            else
            begin
                word_reg <= word_reg + 1'b1;
            end
        end
    end

    // read-modify-write stage payload
    always_ff @(posedge clk)
    begin
        if (cmd.walk)
        begin
            p_addr_reg  <= {row_reg, word_reg};
            p_row_reg   <= row_reg;
            p_first_reg <= (word_reg == w1);
            p_mask_reg  <= mask;
        end
    end

    // control state: configuration, frame, clearing pass, stage and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg        <= 1'b0;
            sw_reg        <= DIM_W'(1024);
            sh_reg        <= DIM_W'(1024);
            frame_reg     <= 1'b0;
            clr_reg       <= '0;
            clr_sel_reg   <= 2'b11;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE: en_reg <= cfg_data[0];
                    CFG_WIDTH:  sw_reg <= cfg_data;
                    CFG_HEIGHT: sh_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (cmd.flip)
            begin
                frame_reg <= !frame_reg;
            end
            if (cmd.clr_start)
            begin
                clr_reg     <= '0;
                clr_sel_reg <= frame_reg ? 2'b01 : 2'b10;
            end
            else if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            p_valid_reg <= cmd.walk;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // shared write addresses
    assign clr_cnt_row = (clr_reg < CNT_ROWS);
    assign dw_waddr    = cmd.clr_step ? clr_reg : p_addr_reg;
    assign cnt_waddr   = cmd.clr_step ? clr_reg[YW-1:0] : p_row_reg;

    // one bitmap and one row counter store per frame
    for (genvar f = 0; f < 2; f++)
    begin : g_frame
        assign dw_we[f] = (cmd.clr_step && clr_sel_reg[f]) ||
                          (p_valid_reg && (frame_reg == 1'(f)));
        assign dw_wdata[f] = cmd.clr_step ? '0 : (dw_rdata[f] | p_mask_reg);

        assign cnt_sum[f] = {1'b0, cnt_rdata[f]} + (COUNT_W+1)'(span);
        assign cnt_we[f]  = (cmd.clr_step && clr_sel_reg[f] && clr_cnt_row) ||
                            (p_valid_reg && p_first_reg && (frame_reg == 1'(f)));
        assign cnt_wdata[f] = cmd.clr_step ? '0 :
                              (cnt_sum[f][COUNT_W] ? COUNT_MAX : cnt_sum[f][COUNT_W-1:0]);

        drbt_ram #(
            .WIDTH (WORD_BITS),
            .DEPTH (FRAME_WORDS)
        ) u_bits (
            .clk   (clk),
            .we    (dw_we[f]),
            .waddr (dw_waddr),
            .wdata (dw_wdata[f]),
            .raddr ({row_reg, word_reg}),
            .rdata (dw_rdata[f])
        );

        drbt_ram #(
            .WIDTH (COUNT_W),
            .DEPTH (MAX_HEIGHT)
        ) u_counts (
            .clk   (clk),
            .we    (cnt_we[f]),
            .waddr (cnt_waddr),
            .wdata (cnt_wdata[f]),
            .raddr (row_reg),
            .rdata (cnt_rdata[f])
        );
    end

    // query result and output register
    always_ff @(posedge clk)
    begin
        if (cmd.q_zero)
        begin
            hold_dirty_reg  <= '0;
            hold_now_reg    <= '0;
            hold_before_reg <= '0;
        end
        else if (cmd.q_capture)
        begin
            hold_dirty_reg  <= dw_rdata[0] | dw_rdata[1];
            hold_now_reg    <= frame_reg ? cnt_rdata[1] : cnt_rdata[0];
            hold_before_reg <= frame_reg ? cnt_rdata[0] : cnt_rdata[1];
        end
        if (cmd.out_load)
        begin
            out_dirty_reg  <= hold_dirty_reg;
            out_now_reg    <= hold_now_reg;
            out_before_reg <= hold_before_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign dirty_word       = out_dirty_reg;
    assign row_count_now    = out_now_reg;
    assign row_count_before = out_before_reg;

    // status to the controller
    assign stat.enable     = en_reg;
    assign stat.func       = func_reg;
    assign stat.rect_empty = (x1_reg > x2_reg) || (row_reg > y2_reg);
    assign stat.walk_last  = (word_reg == w2) && (row_reg == y2_reg);
    assign stat.clr_last   = (clr_reg == CLR_LAST);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    // clearing pass never overlaps a pending bitmap write
    a_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_step && (p_valid_reg || cmd.walk)))
        else $error("clearing pass overlaps rectangle walk");

    // walk stays inside the clamped rectangle
    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> (row_reg <= y2_reg) && (word_reg >= w1) && (word_reg <= w2))
        else $error("rectangle walk left its bounds");

    // a frame switch starts clearing the new current frame only
    a_flip_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flip |=> (clr_reg == '0) && $onehot(clr_sel_reg) && clr_sel_reg[frame_reg])
        else $error("frame switch cleared the wrong frame");

endmodule
`default_nettype wire

>>> rtl/dirty_region_bitmap_tracker.sv
`default_nettype none
// Operation: a query reads the addressed bitmap word and row counts into the
//   output register; a rectangle or pixel mark visits rows * words bitmap words
//   (one read-modify-write per cycle); a frame switch clears one frame.
// Throughput: one operation at a time; the next input is taken once the result
//   sits in the output register. Reset: clearing pass of 32768 words (defaults)
//   over both frames with in_stall high; configuration writes are taken throughout.
// ============================================================================
// dirty_region_bitmap_tracker
// Double-buffered dirty pixel tracker: two frame bitmaps with per-row
// saturating change counters, rectangle and pixel marking, frame switch
// with clear, and query of the combined word and both row counts.
// ============================================================================
module dirty_region_bitmap_tracker
    import drbt_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic        [CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [DIM_W-1:0]     cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic        [1:0]           func,
    input  wire logic signed [COORD_W-1:0]   x_first,
    input  wire logic signed [COORD_W-1:0]   y_first,
    input  wire logic signed [COORD_W-1:0]   x_last,
    input  wire logic signed [COORD_W-1:0]   y_last,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic             [WORD_BITS-1:0] dirty_word,
    output logic             [COUNT_W-1:0]   row_count_now,
    output logic             [COUNT_W-1:0]   row_count_before
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    drbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stores and arithmetic
    drbt_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .func             (func),
        .x_first          (x_first),
        .y_first          (y_first),
        .x_last           (x_last),
        .y_last           (y_last),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .dirty_word       (dirty_word),
        .row_count_now    (row_count_now),
        .row_count_before (row_count_before),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule
`default_nettype wire

>>> verif/tb_dirty_region_bitmap_tracker.sv
// ============================================================================
// tb_dirty_region_bitmap_tracker
// Self-checking bench for the dirty region bitmap tracker. A scoreboard keeps
// its own copy of both frame bitmaps, the per-row counters and the screen
// registers, predicts the answer of every accepted operation and compares it
// field by field with each result transfer. Stimulus is a directed opening,
// randomized phases under several screen settings, and a row counter
// accumulation run, with random idling on both channels and a long output
// hold-off.
// ============================================================================
module tb_dirty_region_bitmap_tracker;
    import drbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORDS_PER_ROW = DEF_MAX_WIDTH / WORD_BITS;
    localparam int FRAME_WORDS   = WORDS_PER_ROW * DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT   = 5000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_AT       = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int PAUSE_AT      = 200;
    localparam int SAT_MARKS     = 20;

    // one operation as seen on the input channel
    typedef struct packed {
        func_t                      op;
        logic signed [COORD_W-1:0]  xf;
        logic signed [COORD_W-1:0]  yf;
        logic signed [COORD_W-1:0]  xl;
        logic signed [COORD_W-1:0]  yl;
    } tracker_op_t;

    // one answer as seen on the output channel
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [COUNT_W-1:0]   now_cnt;
        logic [COUNT_W-1:0]   prev_cnt;
    } tracker_answer_t;

    // mirror of both frames and the screen registers, plus pending answers
    class dirty_map_board;
        logic [WORD_BITS-1:0] pixel_words [2*FRAME_WORDS];
        logic [COUNT_W-1:0]   row_totals [2*DEF_MAX_HEIGHT];
        int                   cur_frame;
        bit                   track_on;
        logic [DIM_W-1:0]     width_reg;
        logic [DIM_W-1:0]     height_reg;
        tracker_answer_t      pending_answers [$];
        int                   mismatches;

        function new();
            foreach (pixel_words[i]) pixel_words[i] = '0;
            foreach (row_totals[i]) row_totals[i] = '0;
            cur_frame  = 0;
            track_on   = 1'b0;
            width_reg  = DIM_W'(DEF_MAX_WIDTH);
            height_reg = DIM_W'(DEF_MAX_HEIGHT);
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            case (idx)
                CFG_ENABLE: track_on = data[0];
                CFG_WIDTH:  width_reg = data;
                CFG_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        // screen size register limited to 1 .. max
        function int eff_dim(logic [DIM_W-1:0] reg_val, int max_val);
            int d;
            d = int'(reg_val);
            if (d < 1) d = 1;
            if (d > max_val) d = max_val;
            return d;
        endfunction

        function int clamp_coord(int v, int lim);
            if (v >= lim) v = lim - 1;
            if (v < 0) v = 0;
            return v;
        endfunction

        // set bits and add to row counts of the current frame
        function void mark_area(int x1, int y1, int x2, int y2);
            int r;
            int k;
            int lo;
            int hi;
            int sum;
            int idx;
            logic [WORD_BITS-1:0] m;
            if (x1 > x2 || y1 > y2) return;
            for (r = y1; r <= y2; r++)
            begin
                idx = cur_frame * DEF_MAX_HEIGHT + r;
                sum = int'(row_totals[idx]) + (x2 - x1 + 1);
                row_totals[idx] = (sum > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(sum);
                for (k = x1 / WORD_BITS; k <= x2 / WORD_BITS; k++)
                begin
                    lo = ((x1 > k * WORD_BITS) ? x1 : k * WORD_BITS) - k * WORD_BITS;
                    hi = ((x2 < k * WORD_BITS + 31) ? x2 : k * WORD_BITS + 31)
                         - k * WORD_BITS;
                    m  = 32'hFFFF_FFFF >> (31 - (hi - lo));
                    m  = m << lo;
                    idx = cur_frame * FRAME_WORDS + r * WORDS_PER_ROW + k;
                    pixel_words[idx] = pixel_words[idx] | m;
                end
            end
        endfunction

        // apply one accepted operation and queue its answer
        function void note_op(tracker_op_t t);
            tracker_answer_t ans;
            int w;
            int h;
            int xa;
            int ya;
            int xb;
            int yb;
            int off;
            int i;
            w   = eff_dim(width_reg, DEF_MAX_WIDTH);
            h   = eff_dim(height_reg, DEF_MAX_HEIGHT);
            xa  = clamp_coord(int'($signed(t.xf)), w);
            ya  = clamp_coord(int'($signed(t.yf)), h);
            xb  = clamp_coord(int'($signed(t.xl)), w);
            yb  = clamp_coord(int'($signed(t.yl)), h);
            ans = '0;
            if (track_on)
            begin
                case (t.op)
                    FUNC_RECT:  mark_area(xa, ya, xb, yb);
                    FUNC_PIXEL: mark_area(xa, ya, xa, ya);
                    FUNC_SWITCH:
                    begin
                        cur_frame = 1 - cur_frame;
                        for (i = 0; i < FRAME_WORDS; i++)
                            pixel_words[cur_frame * FRAME_WORDS + i] = '0;
                        for (i = 0; i < DEF_MAX_HEIGHT; i++)
                            row_totals[cur_frame * DEF_MAX_HEIGHT + i] = '0;
                    end
                    default:
                    begin
                        off = ya * WORDS_PER_ROW + xa / WORD_BITS;
                        ans.word     = pixel_words[off] | pixel_words[FRAME_WORDS + off];
                        ans.now_cnt  = row_totals[cur_frame * DEF_MAX_HEIGHT + ya];
                        ans.prev_cnt = row_totals[(1 - cur_frame) * DEF_MAX_HEIGHT + ya];
                    end
                endcase
            end
            pending_answers.push_back(ans);
        endfunction

        // compare one result transfer with the oldest pending answer
        function void check_answer(tracker_answer_t got);
            tracker_answer_t exp_ans;
            if (pending_answers.size() == 0)
            begin
                $error("result transfer with no pending operation");
                mismatches++;
                return;
            end
            exp_ans = pending_answers.pop_front();
            if (got.word !== exp_ans.word)
            begin
                $error("dirty_word: expected %h, got %h", exp_ans.word, got.word);
                mismatches++;
            end
            if (got.now_cnt !== exp_ans.now_cnt)
            begin
                $error("row_count_now: expected %0d, got %0d", exp_ans.now_cnt, got.now_cnt);
                mismatches++;
            end
            if (got.prev_cnt !== exp_ans.prev_cnt)
            begin
                $error("row_count_before: expected %0d, got %0d",
                       exp_ans.prev_cnt, got.prev_cnt);
                mismatches++;
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic        [CFG_IDX_W-1:0] cfg_index;
    logic        [DIM_W-1:0]     cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic        [1:0]           func;
    logic signed [COORD_W-1:0]   x_first;
    logic signed [COORD_W-1:0]   y_first;
    logic signed [COORD_W-1:0]   x_last;
    logic signed [COORD_W-1:0]   y_last;
    logic                        out_valid;
    logic                        out_stall;
    logic        [WORD_BITS-1:0] dirty_word;
    logic        [COUNT_W-1:0]   row_count_now;
    logic        [COUNT_W-1:0]   row_count_before;

    dirty_map_board board = new();

    int idle_max;
    int random_sent;
    int last_x;
    int last_y;
    int sat_row;
    int cycle_count;
    int answers_taken;
    int recv_wait;
    int recv_hold;
    int recv_idle_max;

    dirty_region_bitmap_tracker dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .x_first          (x_first),
        .y_first          (y_first),
        .x_last           (x_last),
        .y_last           (y_last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .dirty_word       (dirty_word),
        .row_count_now    (row_count_now),
        .row_count_before (row_count_before)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_dirty_region_bitmap_tracker NOT OK");
            $finish;
        end
    end

    // result side: check each transfer, then draw the stall for the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                board.check_answer({dirty_word, row_count_now, row_count_before});
                answers_taken++;
                if (answers_taken % 40 == 0)
                    recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
                recv_wait = $urandom_range(0, recv_idle_max);
                if (answers_taken == HOLD_AT)
                    recv_hold = HOLD_CYCLES;
            end
            if (recv_hold > 0)
            begin
                out_stall <= 1'b1;
                recv_hold--;
            end
            else if (recv_wait > 0)
            begin
                out_stall <= 1'b1;
                recv_wait--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic tracker_op_t make_op(func_t f, int xf, int yf, int xl, int yl);
        tracker_op_t t;
        t.op = f;
        t.xf = COORD_W'(xf);
        t.yf = COORD_W'(yf);
        t.xl = COORD_W'(xl);
        t.yl = COORD_W'(yl);
        return t;
    endfunction

    // mostly small on-screen work near the edges, some full-range values
    function automatic tracker_op_t random_op(int w, int h);
        int pick;
        int xf;
        int yf;
        int xl;
        int yl;
        pick = $urandom_range(0, 99);
        xf   = $urandom_range(0, w + 15) - 8;
        yf   = $urandom_range(0, h + 15) - 8;
        xl   = xf + $urandom_range(0, 70);
        yl   = yf + $urandom_range(0, 3);
        if ($urandom_range(0, 63) == 0)
            return make_op(FUNC_SWITCH, $urandom, $urandom, $urandom, $urandom);
        if (pick < 40)
        begin
            if ($urandom_range(0, 9) == 0)
                xl = xf - $urandom_range(1, 20);
            if ($urandom_range(0, 11) == 0)
                yl = yf - $urandom_range(1, 3);
            if ($urandom_range(0, 39) == 0)
            begin
                xf = $urandom;
                yf = $urandom;
                xl = $urandom;
                yl = $urandom;
            end
            last_x = xf;
            last_y = yf;
            return make_op(FUNC_RECT, xf, yf, xl, yl);
        end
        if (pick < 65)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                xf = $urandom;
                yf = $urandom;
            end
            last_x = xf;
            last_y = yf;
            return make_op(FUNC_PIXEL, xf, yf, $urandom, $urandom);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            xf = $urandom;
            yf = $urandom;
        end
        else if ($urandom_range(0, 9) < 6)
        begin
            xf = last_x + $urandom_range(0, 40) - 8;
            yf = last_y;
        end
        return make_op(FUNC_QUERY, xf, yf, $urandom, $urandom);
    endfunction

    // offer one operation after a random gap and wait for its transfer
    task automatic send_op(input tracker_op_t t);
        int gap;
        gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= t.op;
        x_first  <= t.xf;
        y_first  <= t.yf;
        x_last   <= t.xl;
        y_last   <= t.yl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_op(t);
    endtask

    // stop offering and wait until every pending answer has been checked
    task automatic settle_block();
        in_valid <= 1'b0;
        while (board.pending_answers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_screen(input logic [DIM_W-1:0] en_word,
                                  input logic [DIM_W-1:0] w_word,
                                  input logic [DIM_W-1:0] h_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ENABLE;
        cfg_data  <= en_word;
        @(posedge clk);
        board.write_reg(CFG_ENABLE, en_word);
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w_word;
        @(posedge clk);
        board.write_reg(CFG_WIDTH, w_word);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h_word;
        @(posedge clk);
        board.write_reg(CFG_HEIGHT, h_word);
        cfg_we <= 1'b0;
    endtask

    // one screen setting followed by random operations
    task automatic run_phase(input logic [DIM_W-1:0] en_word,
                             input logic [DIM_W-1:0] w_word,
                             input logic [DIM_W-1:0] h_word,
                             input int n_items);
        int w;
        int h;
        int i;
        settle_block();
        program_screen(en_word, w_word, h_word);
        w = board.eff_dim(board.width_reg, DEF_MAX_WIDTH);
        h = board.eff_dim(board.height_reg, DEF_MAX_HEIGHT);
        for (i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
                idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            if (random_sent == PAUSE_AT)
                settle_block();
            send_op(random_op(w, h));
            if (board.track_on)
                random_sent++;
        end
    endtask

    // main sequence
    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_ENABLE;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        func          <= FUNC_RECT;
        x_first       <= '0;
        y_first       <= '0;
        x_last        <= '0;
        y_last        <= '0;
        out_stall     <= 1'b0;
        cycle_count   <= 0;
        answers_taken = 0;
        recv_wait     = 0;
        recv_hold     = 0;
        recv_idle_max = 8;
        idle_max      = 8;
        random_sent   = 0;
        last_x        = 0;
        last_y        = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled after reset: everything ignored, answers all zero
        send_op(make_op(FUNC_RECT, -4096, -4096, 4095, 4095));
        send_op(make_op(FUNC_SWITCH, 0, 0, 0, 0));
        send_op(make_op(FUNC_QUERY, 0, 0, 0, 0));
        settle_block();
        program_screen(11'd1, 11'd1024, 11'd1024);

        // directed: full word, extreme corners, clamping, inversion, frame flips
        send_op(make_op(FUNC_RECT, 0, 0, 31, 0));
        send_op(make_op(FUNC_QUERY, 0, 0, 0, 0));
        send_op(make_op(FUNC_PIXEL, 1023, 1023, 0, 0));
        send_op(make_op(FUNC_QUERY, 1023, 1023, 0, 0));
        send_op(make_op(FUNC_RECT, -4096, 4095, 40, 4095));
        send_op(make_op(FUNC_QUERY, -1, 4095, -1, -1));
        send_op(make_op(FUNC_RECT, 100, 10, 50, 12));
        send_op(make_op(FUNC_RECT, 50, 12, 100, 10));
        send_op(make_op(FUNC_QUERY, 64, 10, 0, 0));
        send_op(make_op(FUNC_PIXEL, 4095, -4096, -4096, 4095));
        send_op(make_op(FUNC_QUERY, 1000, 0, 0, 0));
        send_op(make_op(FUNC_RECT, 5, 2, 70, 3));
        send_op(make_op(FUNC_QUERY, 64, 3, 0, 0));
        send_op(make_op(FUNC_QUERY, 33, 2, 0, 0));
        send_op(make_op(FUNC_SWITCH, 0, 0, 0, 0));
        send_op(make_op(FUNC_QUERY, 0, 0, 0, 0));
        send_op(make_op(FUNC_PIXEL, 0, 0, 0, 0));
        send_op(make_op(FUNC_QUERY, 0, 0, 0, 0));
        send_op(make_op(FUNC_SWITCH, 0, 0, 0, 0));
        send_op(make_op(FUNC_QUERY, 0, 0, 0, 0));

        // random phases over several screen settings
        run_phase(11'd1, 11'd1024, 11'd1024, 70);
        run_phase(11'd1, 11'd1, 11'd1, 40);
        run_phase(11'd1, 11'd0, 11'd2047, 50);
        run_phase(11'd1, 11'd37, 11'd13, 60);
        run_phase(11'h7FE, 11'd100, 11'd100, 20);
        run_phase(11'd1, 11'd2047, 11'd0, 40);
        run_phase(11'd1, 11'd300, 11'd700, 40);
        run_phase(11'h7FF, DIM_W'($urandom_range(1, 1024)),
                  DIM_W'($urandom_range(1, 1024)), 40);

        // row counter accumulation with full-width single-row marks
        settle_block();
        program_screen(11'd1, 11'd1024, 11'd1024);
        idle_max = 0;
        sat_row  = $urandom_range(0, DEF_MAX_HEIGHT - 1);
        repeat (SAT_MARKS) send_op(make_op(FUNC_RECT, -4096, sat_row, 4095, sat_row));
        idle_max = 8;
        send_op(make_op(FUNC_QUERY, $urandom_range(0, 1023), sat_row, 0, 0));
        send_op(make_op(FUNC_PIXEL, 7, sat_row, 0, 0));
        send_op(make_op(FUNC_QUERY, 7, sat_row, 0, 0));

        // drain and report
        in_valid <= 1'b0;
        while (board.pending_answers.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending_answers.size() == 0)
            $display("tb_dirty_region_bitmap_tracker OK");
        else
            $display("tb_dirty_region_bitmap_tracker NOT OK");
        $finish;
    end

endmodule
